// ===== rtl/broadcast_ring_multi_reader_macros.svh =====
// Assertion macros shared by the broadcast ring RTL.
`ifndef BROADCAST_RING_MULTI_READER_MACROS_SVH
`define BROADCAST_RING_MULTI_READER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define BRMR_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle check");

// Next-cycle implication, disabled while reset is high.
`define BRMR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle check");

`endif

// ===== rtl/brmr_pkg.sv =====
// Package with the sizes, opcodes and state type of the broadcast ring.
`default_nettype none

package brmr_pkg;

   // Ring geometry and word sizes.
   localparam int DEPTH       = 16;
   localparam int NUM_READERS = 4;
   localparam int DATA_WIDTH  = 64;
   localparam int SEQ_WIDTH   = 32;
   localparam int IDX_W       = $clog2(DEPTH);
   localparam int RID_W       = (NUM_READERS > 1) ? $clog2(NUM_READERS) : 1;

   // Port field widths.
   localparam int OPCODE_W   = 2;
   localparam int READER_W   = 2;
   localparam int WORD_W     = 64;

   // Operation codes carried on the request channel.
   typedef enum logic [OPCODE_W-1:0] {
      OP_WRITE       = 2'd0,
      OP_READ_NEXT   = 2'd1,
      OP_READ_LATEST = 2'd2,
      OP_ATTACH      = 2'd3
   } opcode_type;

   // Control sequencer states.
   typedef enum logic {
      S_IDLE = 1'b0,
      S_EXEC = 1'b1
   } state_type;

endpackage

`default_nettype wire

// ===== rtl/broadcast_ring_multi_reader.sv =====
// Top level of the broadcast ring: slot memory, reader table and sequencer.
`default_nettype none

`include "broadcast_ring_multi_reader_macros.svh"

// One writer stores words into a ring of DEPTH slots, tagging each with a
// 32-bit sequence number; up to NUM_READERS readers each track the next
// sequence they expect and skip ahead when they have been lapped. Every
// request word yields exactly one response word. On acceptance of a
// request the slot memory is read synchronously; then, in the execute
// state once the response register is free, the slot is tested, the
// response register is loaded and the slot, write counter and reader
// table are written back. Only one request is in flight: a new one is
// taken in the idle state after the last write-back, so a read never
// overlaps a write-back; a finished response may still wait. A stalled
// response holds the execute state until the response register frees.
module broadcast_ring_multi_reader (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_opcode,
   input  wire logic [1:0]  req_reader_id,
   input  wire logic [63:0] req_write_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_valid_res,
   output logic [63:0]      rsp_read_data,
   output logic [31:0]      rsp_sequence_res
);

   localparam int IDX_W = brmr_pkg::IDX_W;
   localparam int RID_W = brmr_pkg::RID_W;
   localparam int SEQ_W = brmr_pkg::SEQ_WIDTH;
   localparam int DW    = brmr_pkg::DATA_WIDTH;
   localparam int NR    = brmr_pkg::NUM_READERS;
   localparam int DEP   = brmr_pkg::DEPTH;
   localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(DEP - 1);

   // Slot storage.
   logic [SEQ_W-1:0] slot_seq_mem  [DEP];
   logic [DW-1:0]    slot_data_mem [DEP];
   logic [DEP-1:0]   slot_valid_ff, slot_valid_in;

   // Control and bookkeeping registers.
   brmr_pkg::state_type  state_ff, state_in;
   brmr_pkg::opcode_type op_ff;
   logic [RID_W-1:0]     rid_ff;
   logic                 rid_ok_ff;
   logic [DW-1:0]        data_ff;
   logic [IDX_W-1:0]     rd_addr_ff, rd_addr_in;
   logic [SEQ_W-1:0]     rd_seq_ff;
   logic [DW-1:0]        rd_data_ff;
   logic                 rd_valid_ff;
   logic [SEQ_W-1:0]     wc_ff, wc_in;
   logic [IDX_W-1:0]     wr_slot_ff, wr_slot_in;
   logic [SEQ_W-1:0]     reader_next_ff [NR];
   logic [SEQ_W-1:0]     reader_next_in [NR];
   logic [IDX_W-1:0]     reader_slot_ff [NR];
   logic [IDX_W-1:0]     reader_slot_in [NR];

   // Response register.
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_hit_ff, rsp_hit_in;
   logic [63:0]          rsp_data_ff, rsp_data_in;
   logic [31:0]          rsp_seq_ff, rsp_seq_in;

   // Datapath signals.
   logic                 accept;
   logic                 out_free;
   logic                 commit;
   logic                 req_rid_ok;
   logic [RID_W-1:0]     req_rid;
   logic [SEQ_W-1:0]     slot_seq;
   logic [SEQ_W-1:0]     cur_next;
   logic [SEQ_W-1:0]     diff;
   logic [SEQ_W-1:0]     wc_inc;
   logic [IDX_W-1:0]     wr_slot_inc;
   logic [IDX_W-1:0]     rd_slot_inc;
   logic                 is_read;
   logic                 hit;
   logic                 do_write;

   // Request decode at the input.
   assign req_rid    = RID_W'(req_reader_id);
   assign req_rid_ok = (32'(req_reader_id) < 32'(NR));
   assign accept     = req_valid && req_ready;
   assign out_free   = !rsp_valid_ff || rsp_ready;

   // The slot to read is the reader's expected slot or the newest slot.
   always_comb begin
      rd_addr_in = wr_slot_ff;
      if ((brmr_pkg::opcode_type'(req_opcode) == brmr_pkg::OP_READ_NEXT) && req_rid_ok) begin
         rd_addr_in = reader_slot_ff[req_rid];
      end
   end

   // Next-state logic of the sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         brmr_pkg::S_IDLE: begin
            if (req_valid) begin
               state_in = brmr_pkg::S_EXEC;
            end
         end
         brmr_pkg::S_EXEC: begin
            if (out_free) begin
               state_in = brmr_pkg::S_IDLE;
            end
         end
         default: state_in = brmr_pkg::S_IDLE;
      endcase
   end

   // Output logic of the sequencer.
   always_comb begin
      req_ready = 1'b0;
      commit    = 1'b0;
      unique case (state_ff)
         brmr_pkg::S_IDLE: req_ready = 1'b1;
         brmr_pkg::S_EXEC: commit    = out_free;
         default: begin
            req_ready = 1'b0;
            commit    = 1'b0;
         end
      endcase
   end

   // Slot test: a slot never written reads as sequence zero.
   always_comb begin
      slot_seq    = rd_valid_ff ? rd_seq_ff : '0;
      cur_next    = rid_ok_ff ? reader_next_ff[rid_ff] : '0;
      diff        = slot_seq - cur_next;
      is_read     = (op_ff == brmr_pkg::OP_READ_NEXT) || (op_ff == brmr_pkg::OP_READ_LATEST);
      hit         = rid_ok_ff && is_read && !diff[SEQ_W-1];
      do_write    = (op_ff == brmr_pkg::OP_WRITE);
      wc_inc      = wc_ff + SEQ_W'(1);
      wr_slot_inc = (wr_slot_ff == LAST_SLOT) ? '0 : wr_slot_ff + IDX_W'(1);
      rd_slot_inc = (rd_addr_ff == LAST_SLOT) ? '0 : rd_addr_ff + IDX_W'(1);
   end

   // Write-back values for the counter, valid bits and reader table.
   always_comb begin
      wc_in         = wc_ff;
      wr_slot_in    = wr_slot_ff;
      slot_valid_in = slot_valid_ff;
      for (int r = 0; r < NR; r++) begin
         reader_next_in[r] = reader_next_ff[r];
         reader_slot_in[r] = reader_slot_ff[r];
      end
      if (commit) begin
         if (do_write) begin
            wc_in                      = wc_inc;
            wr_slot_in                 = wr_slot_inc;
            slot_valid_in[wr_slot_inc] = 1'b1;
         end else if (hit) begin
            reader_next_in[rid_ff] = slot_seq + SEQ_W'(1);
            reader_slot_in[rid_ff] = rd_slot_inc;
         end else if ((op_ff == brmr_pkg::OP_ATTACH) && rid_ok_ff) begin
            reader_next_in[rid_ff] = wc_inc;
            reader_slot_in[rid_ff] = wr_slot_inc;
         end
      end
   end

   // Response word contents.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_hit_in   = rsp_hit_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_seq_in   = rsp_seq_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
         rsp_hit_in   = 1'b0;
         rsp_data_in  = '0;
         rsp_seq_in   = '0;
         if (do_write) begin
            rsp_seq_in = wc_inc;
         end else if (hit) begin
            rsp_hit_in  = 1'b1;
            rsp_data_in = 64'(rd_data_ff);
            rsp_seq_in  = slot_seq;
         end
      end
   end

   // Slot memory: synchronous read on acceptance, write at write-back.
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_seq_ff  <= slot_seq_mem[rd_addr_in];
         rd_data_ff <= slot_data_mem[rd_addr_in];
      end
      if (commit && do_write) begin
         slot_seq_mem[wr_slot_inc]  <= wc_inc;
         slot_data_mem[wr_slot_inc] <= data_ff;
      end
   end

   // Request capture; payload registers need no reset.
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff       <= brmr_pkg::opcode_type'(req_opcode);
         rid_ff      <= req_rid_ok ? req_rid : '0;
         rid_ok_ff   <= req_rid_ok;
         data_ff     <= DW'(req_write_data);
         rd_addr_ff  <= rd_addr_in;
         rd_valid_ff <= slot_valid_ff[rd_addr_in];
      end
      rsp_hit_ff  <= rsp_hit_in;
      rsp_data_ff <= rsp_data_in;
      rsp_seq_ff  <= rsp_seq_in;
   end

   // Control state with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= brmr_pkg::S_IDLE;
         rsp_valid_ff  <= 1'b0;
         wc_ff         <= '0;
         wr_slot_ff    <= '0;
         slot_valid_ff <= '0;
         for (int r = 0; r < NR; r++) begin
            reader_next_ff[r] <= SEQ_W'(1);
            reader_slot_ff[r] <= IDX_W'(1);
         end
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         wc_ff         <= wc_in;
         wr_slot_ff    <= wr_slot_in;
         slot_valid_ff <= slot_valid_in;
         for (int r = 0; r < NR; r++) begin
            reader_next_ff[r] <= reader_next_in[r];
            reader_slot_ff[r] <= reader_slot_in[r];
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_valid_res    = rsp_hit_ff;
   assign rsp_read_data    = rsp_data_ff;
   assign rsp_sequence_res = rsp_seq_ff;

   // A write-back of a write reports the advanced counter.
   `BRMR_ASSERT_NEXT(a_write_seq, clock, reset, commit && do_write, rsp_valid && !rsp_valid_res && (rsp_sequence_res == wc_ff) && (wc_ff == $past(wc_ff) + 32'd1))
   // An accepted word always occupies the sequencer for the next cycle.
   `BRMR_ASSERT_NEXT(a_accept_exec, clock, reset, accept, (state_ff == brmr_pkg::S_EXEC) && !req_ready)
   // A returned entry always carries the sequence the reader now expects minus one.
   `BRMR_ASSERT_NEXT(a_hit_advance, clock, reset, commit && hit, rsp_valid_res && (reader_next_ff[$past(rid_ff)] == rsp_sequence_res + 32'd1))

endmodule

`default_nettype wire
